FILE: sv/assert_macros.svh
// assertion macros shared by the euclidean distance rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define ED3D_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property that must hold in the cycle after its trigger
`define ED3D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ed3d_pkg.sv
// shared constants for the euclidean distance pipeline
package ed3d_pkg;

  // radicand bits taken in by one square root digit step
  localparam int unsigned STEP_BITS = 2;

  // number of coordinate fields packed in one input request
  localparam int unsigned NUM_COORDS = 6;

endpackage

FILE: sv/ed3d_root_step.sv
// one digit step of the restoring integer square root
module ed3d_root_step #(
  parameter int unsigned ROOT_BITS = 25
) (
  input  logic [ROOT_BITS+1:0]             rem_i,
  input  logic [ROOT_BITS-1:0]             root_i,
  input  logic [ed3d_pkg::STEP_BITS-1:0]   pair_i,
  output logic [ROOT_BITS+1:0]             rem_o,
  output logic [ROOT_BITS-1:0]             root_o
);

  localparam int unsigned SH_W = ROOT_BITS + 2 + ed3d_pkg::STEP_BITS;

  logic [SH_W-1:0] rem_sh;
  logic [SH_W-1:0] trial;
  logic [SH_W-1:0] diff;
  logic            fits;

  // bring down the next radicand pair and try the candidate digit
  always_comb begin
    rem_sh = {rem_i, pair_i};
    trial  = {{(SH_W-ROOT_BITS-2){1'b0}}, root_i, 2'b01};
    fits   = (rem_sh >= trial);
    diff   = rem_sh - trial;
    rem_o  = fits ? diff[ROOT_BITS+1:0] : rem_sh[ROOT_BITS+1:0];
    root_o = {root_i[ROOT_BITS-2:0], fits};
  end

endmodule

FILE: sv/euclidean_distance_3d.sv
// Euclidean distance between two 3D fixed-point points, fully pipelined.
// One request enters per cycle and one result leaves per cycle for as long as
// the output side keeps taking them. There is one register stage each for the
// axis differences, the three squares and their sum, then one stage per result
// bit of the digit-by-digit square root, whose COORD_BITS+1 steps set the
// depth. Every stage has its own valid bit and holds its request when the stage
// after it is full and cannot move on, so bubbles are squeezed out and a waiting
// result never blocks new input while empty stages remain. The square root is
// truncated toward zero; the result carries the same number of fraction bits as
// the coordinates.
`include "assert_macros.svh"

module euclidean_distance_3d #(
  parameter int unsigned COORD_BITS = 24,
  localparam int unsigned IN_W  = ((ed3d_pkg::NUM_COORDS*COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((COORD_BITS + 1 + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, zero fill
  input  logic [IN_W-1:0]     in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // distance, zero fill
  output logic [OUT_W-1:0]    out_tdata
);

  localparam int unsigned ROOT_W = COORD_BITS + 1;
  localparam int unsigned SQ_W   = 2 * COORD_BITS;
  localparam int unsigned SUM_W  = 2 * ROOT_W;
  localparam int unsigned NS     = 3 + ROOT_W;
  localparam int unsigned SB     = ed3d_pkg::STEP_BITS;

  // per-stage valid bits and advance enables
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  // stage payloads
  logic [COORD_BITS-1:0] dx_r, dy_r, dz_r;
  logic [COORD_BITS-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic [SQ_W-1:0]       sqx_r, sqy_r, sqz_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SUM_W-1:0]      sum_nxt;
  logic [SUM_W-1:0]      rad_r   [ROOT_W-1];
  logic [ROOT_W-1:0]     root_r  [ROOT_W];
  logic [ROOT_W+1:0]     rem_r   [ROOT_W];
  logic [ROOT_W-1:0]     root_nxt[ROOT_W];
  logic [ROOT_W+1:0]     rem_nxt [ROOT_W];

  // a stage may load when empty or when its own content moves on
  genvar gi;
  generate
    for (gi = 0; gi < NS; gi++) begin : g_en
      if (gi == NS-1) begin : g_last
        assign en[gi] = !v_r[gi] || out_tready;
      end else begin : g_mid
        assign en[gi] = !v_r[gi] || en[gi+1];
      end
    end
  endgenerate

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];
  assign out_tdata  = {{(OUT_W-ROOT_W){1'b0}}, root_r[ROOT_W-1]};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // absolute per-axis differences
  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic [COORD_BITS-1:0] a,
    input logic [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    logic        [COORD_BITS:0] m;
    begin
      d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
      m = d[COORD_BITS] ? (~d + 1'b1) : d;
      abs_diff = m[COORD_BITS-1:0];
    end
  endfunction

  always_comb begin
    dx_nxt = abs_diff(in_tdata[0*COORD_BITS +: COORD_BITS], in_tdata[3*COORD_BITS +: COORD_BITS]);
    dy_nxt = abs_diff(in_tdata[1*COORD_BITS +: COORD_BITS], in_tdata[4*COORD_BITS +: COORD_BITS]);
    dz_nxt = abs_diff(in_tdata[2*COORD_BITS +: COORD_BITS], in_tdata[5*COORD_BITS +: COORD_BITS]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
    end
  end

  // squares, one multiplier per axis
  always_ff @(posedge clk) begin
    if (en[1]) begin
      sqx_r <= SQ_W'(dx_r) * SQ_W'(dx_r);
      sqy_r <= SQ_W'(dy_r) * SQ_W'(dy_r);
      sqz_r <= SQ_W'(dz_r) * SQ_W'(dz_r);
    end
  end

  // exact sum of squares
  always_comb begin
    sum_nxt = {2'b00, sqx_r} + {2'b00, sqy_r} + {2'b00, sqz_r};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sum_r <= sum_nxt;
    end
  end

  // square root, one result bit per stage
  generate
    for (gi = 0; gi < ROOT_W; gi++) begin : g_root
      logic [SUM_W-1:0] rad_in;
      logic [ROOT_W-1:0] root_in;
      logic [ROOT_W+1:0] rem_in;

      if (gi == 0) begin : g_first
        assign rad_in  = sum_r;
        assign root_in = '0;
        assign rem_in  = '0;
      end else begin : g_next
        assign rad_in  = rad_r[gi-1];
        assign root_in = root_r[gi-1];
        assign rem_in  = rem_r[gi-1];
      end

      ed3d_root_step #(
        .ROOT_BITS(ROOT_W)
      ) u_step (
        .rem_i (rem_in),
        .root_i(root_in),
        .pair_i(rad_in[SUM_W-1 -: SB]),
        .rem_o (rem_nxt[gi]),
        .root_o(root_nxt[gi])
      );

      always_ff @(posedge clk) begin
        if (en[3+gi]) begin
          root_r[gi] <= root_nxt[gi];
          rem_r[gi]  <= rem_nxt[gi];
        end
      end

      // remaining radicand bits move up for the next step
      if (gi < ROOT_W-1) begin : g_rad
        always_ff @(posedge clk) begin
          if (en[3+gi]) begin
            rad_r[gi] <= {rad_in[SUM_W-SB-1:0], {SB{1'b0}}};
          end
        end
      end
    end
  endgenerate

  // checks
  `ED3D_ASSERT_NEXT(a_accept_fills, in_tvalid && in_tready, v_r[0], "accepted request not captured")
  `ED3D_ASSERT_NEXT(a_stall_holds_last, v_r[NS-1] && !out_tready, v_r[NS-1] && $stable(root_r[ROOT_W-1]), "stalled result lost or changed")
  `ED3D_ASSERT_SAME(a_root_rem_bound, v_r[NS-1], rem_r[ROOT_W-1] <= {1'b0, root_r[ROOT_W-1], 1'b0}, "square root remainder out of range")

endmodule
